// ===== hw/rtl/srss_pkg.sv =====
package srss_pkg;

    // Sizes of the pattern and keyword tables.
    localparam int NUM_PAT   = 11;
    localparam int NUM_KW    = 6;
    localparam int NUM_FLAGS = 12;
    localparam int PAT_MAX   = 18;
    localparam int KW_MAX    = 8;

    // Window patterns, right-aligned: the last character sits in bits [7:0].
    localparam logic [8*PAT_MAX-1:0] PAT_STR [NUM_PAT] = '{
        "SELECT *", "UNION SELECT", " OR 1=1", " OR TRUE", "--", "/*",
        "SLEEP(", "BENCHMARK(", {"INFORMATION_", "SCHEMA"}, "WHERE", "LIMIT"
    };
    localparam int PAT_LEN [NUM_PAT] = '{8, 12, 7, 8, 2, 2, 6, 10, 18, 5, 5};

    // Pattern positions in the seen vector.
    localparam int PAT_SELECT_STAR = 0;
    localparam int PAT_UNION       = 1;
    localparam int PAT_OR_ONE      = 2;
    localparam int PAT_OR_TRUE     = 3;
    localparam int PAT_DASH_DASH   = 4;
    localparam int PAT_SLASH_STAR  = 5;
    localparam int PAT_SLEEP       = 6;
    localparam int PAT_BENCHMARK   = 7;
    localparam int PAT_INFO_SCHEMA = 8;
    localparam int PAT_WHERE       = 9;
    localparam int PAT_LIMIT       = 10;

    // Statement keywords, padded with spaces to eight characters.
    // Character i of a keyword sits in byte (KW_MAX-1-i).
    localparam logic [8*KW_MAX-1:0] KW_STR [NUM_KW] = '{
        "DELETE  ", "UPDATE  ", "SELECT  ", "DROP    ", "TRUNCATE", "ALTER   "
    };
    localparam int KW_LEN [NUM_KW] = '{6, 6, 6, 4, 8, 5};

    localparam int KW_DELETE   = 0;
    localparam int KW_UPDATE   = 1;
    localparam int KW_SELECT   = 2;
    localparam int KW_DROP     = 3;
    localparam int KW_TRUNCATE = 4;
    localparam int KW_ALTER    = 5;

    // Flag bit positions.
    localparam int FLAG_EMPTY       = 0;
    localparam int FLAG_MULTI       = 1;
    localparam int FLAG_DELETE      = 2;
    localparam int FLAG_UPDATE      = 3;
    localparam int FLAG_SELECT_STAR = 4;
    localparam int FLAG_UNION       = 5;
    localparam int FLAG_TAUTOLOGY   = 6;
    localparam int FLAG_COMMENT     = 7;
    localparam int FLAG_SCHEMA      = 8;
    localparam int FLAG_TIME_PROBE  = 9;
    localparam int FLAG_UNBALANCED  = 10;
    localparam int FLAG_INFO_SCHEMA = 11;

    // Risk weights in hundredths, one per flag.
    localparam logic [6:0] FLAG_WEIGHT [NUM_FLAGS] = '{
        7'd80, 7'd45, 7'd96, 7'd92, 7'd30, 7'd35,
        7'd50, 7'd20, 7'd75, 7'd45, 7'd24, 7'd20
    };

    localparam logic [6:0] RISK_BASE  = 7'd2;
    localparam logic [6:0] RISK_MAX   = 7'd100;
    localparam logic [6:0] RISK_BLOCK = 7'd85;
    localparam logic [6:0] RISK_EMPTY = 7'd82;

    typedef enum logic [2:0] {
        VERDICT_OK         = 3'd0,
        VERDICT_WARN       = 3'd1,
        VERDICT_DELETE     = 3'd2,
        VERDICT_UPDATE     = 3'd3,
        VERDICT_MULTI      = 3'd4,
        VERDICT_SUSPICIOUS = 3'd5,
        VERDICT_EMPTY      = 3'd6
    } verdict_t;

    typedef enum logic [2:0] {
        PHASE_SKIP = 3'b001,
        PHASE_WORD = 3'b010,
        PHASE_DONE = 3'b100
    } word_phase_t;

    // Character classes.
    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// ===== hw/rtl/sql_risk_stream_scanner.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// input    | in        | in_valid / in_stall    | action, text_byte
// output   | out       | out_valid / out_stall  | allowed, flags, risk_hundredths, verdict
// config   | in        | cfg_write              | cfg_data (strict mode)
//
// One input transfer per cycle while in_stall is low; a text byte updates the scan state at its edge.
// An end-of-query transfer computes the verdict from the state in the same cycle
// and registers the result in the output register.
// in_stall rises only while a result waits in the output register under out_stall;
// text bytes and end markers both wait then.
// Reset clears all scan state, sets strict mode and empties the output register.
module sql_risk_stream_scanner #(
    parameter int WINDOW_DEPTH = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        allowed,
    output logic [11:0] flags,
    output logic [6:0]  risk_hundredths,
    output logic [2:0]  verdict
);
    import srss_pkg::*;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Configuration and scan state.
    logic                  strict_reg;
    logic                  sq_reg, sq_next;
    logic                  dq_reg, dq_next;
    logic                  txt_reg, txt_next;
    logic [1:0]            stmt_reg, stmt_next;
    word_phase_t           phase_reg, phase_next;
    logic [5:0]            wlen_reg, wlen_next;
    logic [NUM_KW-1:0]     cand_reg, cand_next;
    logic [NUM_PAT-1:0]    seen_reg, seen_next;
    logic [7:0]            recent_reg [WINDOW_DEPTH];
    logic [7:0]            recent_next [WINDOW_DEPTH];
    logic                  ended_reg, ended_next;
    logic                  any_reg, any_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  allowed_reg;
    logic [11:0]           flags_reg;
    logic [6:0]            risk_reg;
    logic [2:0]            verdict_reg;

    logic                  in_fire, byte_take, end_fire;
    logic [7:0]            u;
    logic [7:0]            win [PAT_MAX];
    logic [NUM_PAT-1:0]    pat_hit;
    logic [NUM_KW-1:0]     char_ok, len_keep;

    logic [NUM_KW-1:0]     cand_eff;
    logic                  multi;
    logic [11:0]           flag_vec;
    logic [9:0]            sum_lo, sum_hi, risk_sum;
    logic [6:0]            risk_val;
    logic                  allow_val;
    verdict_t              verdict_val;

    // A result waiting under stall holds back the input side.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign end_fire  = in_fire && action;
    assign byte_take = in_fire && !action && !ended_reg && text_byte != CH_NUL;
    assign u         = fold_upper(text_byte);

    // Window seen by the matchers: the new byte, then the most recent ones.
    always_comb
    begin
        win[0] = u;
        for (int k = 1; k < PAT_MAX; k++)
        begin
            win[k] = recent_reg[k-1];
        end
    end

    // Pattern matchers, all in parallel.
    always_comb
    begin
        for (int p = 0; p < NUM_PAT; p++)
        begin
            pat_hit[p] = 1'b1;
            for (int k = 0; k < PAT_MAX; k++)
            begin
                if (k < PAT_LEN[p] && win[k] != PAT_STR[p][8*k +: 8])
                begin
                    pat_hit[p] = 1'b0;
                end
            end
        end
    end

    // Keyword tests on the current word position and on the word length.
    always_comb
    begin
        for (int j = 0; j < NUM_KW; j++)
        begin
            char_ok[j]  = 1'b0;
            len_keep[j] = (wlen_reg == 6'(KW_LEN[j]));
            for (int i = 0; i < KW_MAX; i++)
            begin
                if (wlen_reg == 6'(i) && i < KW_LEN[j]
                    && KW_STR[j][8*(KW_MAX-1-i) +: 8] == u)
                begin
                    char_ok[j] = 1'b1;
                end
            end
        end
    end

    // Next scan state for a text byte or a NUL terminator, or a clear on the end of a query.
    always_comb
    begin
        sq_next    = sq_reg;
        dq_next    = dq_reg;
        txt_next   = txt_reg;
        stmt_next  = stmt_reg;
        phase_next = phase_reg;
        wlen_next  = wlen_reg;
        cand_next  = cand_reg;
        seen_next  = seen_reg;
        ended_next = ended_reg;
        any_next   = any_reg;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            recent_next[i] = recent_reg[i];
        end

        if (end_fire)
        begin
            sq_next    = 1'b0;
            dq_next    = 1'b0;
            txt_next   = 1'b0;
            stmt_next  = 2'd0;
            phase_next = PHASE_SKIP;
            wlen_next  = 6'd0;
            cand_next  = '1;
            seen_next  = '0;
            ended_next = 1'b0;
            any_next   = 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                recent_next[i] = 8'h00;
            end
        end
        else if (in_fire && !action && !ended_reg && text_byte == CH_NUL)
        begin
            ended_next = 1'b1;
        end
        else if (byte_take)
        begin
            any_next = 1'b1;

            // Quotes and statement separators.
            if (text_byte == CH_SQUOTE && !dq_reg)
            begin
                sq_next = !sq_reg;
            end
            else if (text_byte == CH_DQUOTE && !sq_reg)
            begin
                dq_next = !dq_reg;
            end
            else if (text_byte == CH_SEMI && !sq_reg && !dq_reg)
            begin
                if (txt_reg)
                begin
                    if (stmt_reg != 2'd2)
                    begin
                        stmt_next = stmt_reg + 2'd1;
                    end
                    txt_next = 1'b0;
                end
            end
            else if (!is_space(text_byte))
            begin
                txt_next = 1'b1;
            end

            // First word capture.
            if (phase_reg == PHASE_WORD || (phase_reg == PHASE_SKIP && is_alpha(text_byte)))
            begin
                if (is_word(text_byte))
                begin
                    phase_next = PHASE_WORD;
                    cand_next  = cand_reg & char_ok;
                    if (wlen_reg != 6'd63)
                    begin
                        wlen_next = wlen_reg + 6'd1;
                    end
                end
                else
                begin
                    phase_next = PHASE_DONE;
                    cand_next  = cand_reg & len_keep;
                end
            end

            // Pattern record and window shift.
            seen_next      = seen_reg | pat_hit;
            recent_next[0] = u;
            for (int i = 1; i < WINDOW_DEPTH; i++)
            begin
                recent_next[i] = recent_reg[i-1];
            end
        end
    end

    // Verdict from the state left by the query's last byte.
    always_comb
    begin
        unique case (phase_reg)
            PHASE_SKIP: cand_eff = '0;
            PHASE_WORD: cand_eff = cand_reg & len_keep;
            PHASE_DONE: cand_eff = cand_reg;
            default:    cand_eff = '0;
        endcase

        multi = (stmt_reg == 2'd2) || (stmt_reg == 2'd1 && txt_reg);

        flag_vec = '0;
        flag_vec[FLAG_MULTI]       = multi;
        flag_vec[FLAG_DELETE]      = cand_eff[KW_DELETE] && !seen_reg[PAT_WHERE];
        flag_vec[FLAG_UPDATE]      = cand_eff[KW_UPDATE] && !seen_reg[PAT_WHERE];
        flag_vec[FLAG_SELECT_STAR] = cand_eff[KW_SELECT] && seen_reg[PAT_SELECT_STAR]
                                     && !seen_reg[PAT_LIMIT];
        flag_vec[FLAG_UNION]       = seen_reg[PAT_UNION];
        flag_vec[FLAG_TAUTOLOGY]   = seen_reg[PAT_OR_ONE] || seen_reg[PAT_OR_TRUE];
        flag_vec[FLAG_COMMENT]     = seen_reg[PAT_DASH_DASH] || seen_reg[PAT_SLASH_STAR];
        flag_vec[FLAG_SCHEMA]      = cand_eff[KW_DROP] || cand_eff[KW_TRUNCATE]
                                     || cand_eff[KW_ALTER];
        flag_vec[FLAG_TIME_PROBE]  = seen_reg[PAT_SLEEP] || seen_reg[PAT_BENCHMARK];
        flag_vec[FLAG_UNBALANCED]  = sq_reg || dq_reg;
        flag_vec[FLAG_INFO_SCHEMA] = seen_reg[PAT_INFO_SCHEMA];

        // Weight sum in two halves, then saturate.
        sum_lo = 10'(RISK_BASE);
        sum_hi = 10'd0;
        for (int b = 0; b < NUM_FLAGS / 2; b++)
        begin
            if (flag_vec[b])
            begin
                sum_lo = sum_lo + 10'(FLAG_WEIGHT[b]);
            end
            if (flag_vec[b + NUM_FLAGS / 2])
            begin
                sum_hi = sum_hi + 10'(FLAG_WEIGHT[b + NUM_FLAGS / 2]);
            end
        end
        risk_sum = sum_lo + sum_hi;
        risk_val = (risk_sum > 10'(RISK_MAX)) ? RISK_MAX : risk_sum[6:0];

        allow_val = !(strict_reg && (flag_vec[FLAG_MULTI] || flag_vec[FLAG_DELETE]
                      || flag_vec[FLAG_UPDATE] || flag_vec[FLAG_SCHEMA]
                      || risk_val >= RISK_BLOCK));

        priority if (allow_val && flag_vec == '0)
        begin
            verdict_val = VERDICT_OK;
        end
        else if (allow_val)
        begin
            verdict_val = VERDICT_WARN;
        end
        else if (flag_vec[FLAG_DELETE])
        begin
            verdict_val = VERDICT_DELETE;
        end
        else if (flag_vec[FLAG_UPDATE])
        begin
            verdict_val = VERDICT_UPDATE;
        end
        else if (flag_vec[FLAG_MULTI])
        begin
            verdict_val = VERDICT_MULTI;
        end
        else
        begin
            verdict_val = VERDICT_SUSPICIOUS;
        end
    end

    // The output register empties on a transfer and fills on an end marker.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (end_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg    <= 1'b1;
            sq_reg        <= 1'b0;
            dq_reg        <= 1'b0;
            txt_reg       <= 1'b0;
            stmt_reg      <= 2'd0;
            phase_reg     <= PHASE_SKIP;
            wlen_reg      <= 6'd0;
            cand_reg      <= '1;
            seen_reg      <= '0;
            ended_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                recent_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                strict_reg <= cfg_data;
            end
            sq_reg        <= sq_next;
            dq_reg        <= dq_next;
            txt_reg       <= txt_next;
            stmt_reg      <= stmt_next;
            phase_reg     <= phase_next;
            wlen_reg      <= wlen_next;
            cand_reg      <= cand_next;
            seen_reg      <= seen_next;
            ended_reg     <= ended_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                recent_reg[i] <= recent_next[i];
            end
        end
    end

    // Result payload, loaded on an end marker.
    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            if (!any_reg)
            begin
                allowed_reg <= 1'b0;
                flags_reg   <= 12'(1) << FLAG_EMPTY;
                risk_reg    <= RISK_EMPTY;
                verdict_reg <= VERDICT_EMPTY;
            end
            else
            begin
                allowed_reg <= allow_val;
                flags_reg   <= flag_vec;
                risk_reg    <= risk_val;
                verdict_reg <= verdict_val;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign allowed         = allowed_reg;
    assign flags           = flags_reg;
    assign risk_hundredths = risk_reg;
    assign verdict         = verdict_reg;

endmodule

// ===== hw/rtl/srss_checker.sv =====
module srss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        allowed,
    input logic [11:0] flags,
    input logic [6:0]  risk_hundredths,
    input logic [2:0]  verdict
);
    import srss_pkg::*;

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(flags) && $stable(verdict)
            && $stable(risk_hundredths) && $stable(allowed))
        else $error("stalled result changed");

    // Input only waits behind a stalled result.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // The empty verdict carries its fixed flags and score.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_EMPTY |->
            flags == 12'd1 && risk_hundredths == RISK_EMPTY && !allowed)
        else $error("empty verdict payload wrong");

    // An allowed query is ok or warned, and a clean query is allowed.
    a_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && allowed |-> verdict == VERDICT_OK || verdict == VERDICT_WARN)
        else $error("allowed query with blocking verdict");

    a_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flags == 12'd0 |->
            allowed && verdict == VERDICT_OK && risk_hundredths == RISK_BASE)
        else $error("clean query not reported as ok");

endmodule

bind sql_risk_stream_scanner srss_checker u_srss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .allowed         (allowed),
    .flags           (flags),
    .risk_hundredths (risk_hundredths),
    .verdict         (verdict)
);
